// ===== sv/xtea_pkg.sv =====
// ----------------------------------------------------------------------------
// XTEA CBC package
// Shared constants, register map and types for the XTEA CBC cipher block.
// ----------------------------------------------------------------------------
package xtea_pkg;

  // XTEA key schedule constant and the shifts of the mixing function.
  localparam logic [31:0] XTEA_DELTA    = 32'h9E3779B9;
  localparam int unsigned MIX_SHL       = 4;
  localparam int unsigned MIX_SHR       = 5;
  localparam int unsigned KEY_SEL_SHIFT = 11;

  // Configuration register map, one register per 32-bit word address.
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned PADDR_W   = REG_IDX_W + 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_DECRYPT_MODE,
    REG_ROUND_COUNT,
    REG_KEY_WORD0,
    REG_KEY_WORD1,
    REG_KEY_WORD2,
    REG_KEY_WORD3,
    REG_IV_LOW,
    REG_IV_HIGH
  } reg_idx_t;

  // The 128-bit key, word i is key word i.
  typedef logic [3:0][31:0] key_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // Control for one half round of the shared round unit.
  typedef struct packed {
    logic sub;     // Subtract the mixed term (decipher) instead of adding it.
    logic sel_hi;  // Select the key word from sum bits 12:11 instead of 1:0.
  } half_op_t;

endpackage

// ===== sv/xtea_cbc_cipher.sv =====
// ----------------------------------------------------------------------------
// XTEA CBC cipher, top level
// A new block is taken only after the previous result is issued. The single
// half-round unit does one half round per cycle, two per XTEA cycle, under
// the round sequencer. Reset (rst_n low, synchronous): the configuration
// and control registers return to their reset values, the chain value
// clears to zero and both channels go idle.
// ----------------------------------------------------------------------------
module xtea_cbc_cipher import xtea_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,

  // Input block channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_block_low,
  input  logic [31:0]        in_block_high,
  input  logic               in_first_block,

  // Result block channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_result_low,
  output logic [31:0]        out_result_high,

  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Configuration registers.
  logic        decrypt_mode_r;
  logic [7:0]  round_count_r;
  key_t        key_r;
  logic [31:0] iv_low_r;
  logic [31:0] iv_high_r;

  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  // Sequencer and datapath.
  state_t      state_r, state_nxt;
  logic [7:0]  rounds_left_r, rounds_left_nxt;
  logic        phase_r, phase_nxt;
  logic [31:0] a_r, a_nxt;
  logic [31:0] b_r, b_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [63:0] xor_r, xor_nxt;
  logic [63:0] chain_r, chain_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_low_r, out_low_nxt;
  logic [31:0] out_high_r, out_high_nxt;

  logic [63:0] chain_sel;
  logic [39:0] start_prod;
  logic        out_free;
  logic        dst_is_b;
  half_op_t    half_op;
  logic [31:0] half_dst;
  logic [31:0] half_src;
  logic [31:0] half_res;

  // Configuration write and read decode.
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decrypt_mode_r <= 1'b0;
      round_count_r  <= 8'd64;
      key_r          <= '0;
      iv_low_r       <= '0;
      iv_high_r      <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DECRYPT_MODE: decrypt_mode_r <= pwdata[0];
        REG_ROUND_COUNT:  round_count_r  <= pwdata[7:0];
        REG_KEY_WORD0:    key_r[0]       <= pwdata;
        REG_KEY_WORD1:    key_r[1]       <= pwdata;
        REG_KEY_WORD2:    key_r[2]       <= pwdata;
        REG_KEY_WORD3:    key_r[3]       <= pwdata;
        REG_IV_LOW:       iv_low_r       <= pwdata;
        REG_IV_HIGH:      iv_high_r      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DECRYPT_MODE: prdata = {31'b0, decrypt_mode_r};
      REG_ROUND_COUNT:  prdata = {24'b0, round_count_r};
      REG_KEY_WORD0:    prdata = key_r[0];
      REG_KEY_WORD1:    prdata = key_r[1];
      REG_KEY_WORD2:    prdata = key_r[2];
      REG_KEY_WORD3:    prdata = key_r[3];
      REG_IV_LOW:       prdata = iv_low_r;
      REG_IV_HIGH:      prdata = iv_high_r;
      default:          prdata = '0;
    endcase
  end

  // Handshake outputs.
  assign in_stall        = (state_r != ST_IDLE);
  assign out_free        = ~out_valid_r | ~out_stall;
  assign out_valid       = out_valid_r;
  assign out_result_low  = out_low_r;
  assign out_result_high = out_high_r;

  // Chain value seen by a new block and the deciphering start sum.
  assign chain_sel  = in_first_block ? {iv_high_r, iv_low_r} : chain_r;
  assign start_prod = XTEA_DELTA * round_count_r;

  // Half round selection: encipher updates a then b, decipher b then a.
  assign dst_is_b = phase_r ^ decrypt_mode_r;
  assign half_op  = '{sub: decrypt_mode_r, sel_hi: dst_is_b};
  assign half_dst = dst_is_b ? b_r : a_r;
  assign half_src = dst_is_b ? a_r : b_r;

  xtea_half u_half (
    .op  (half_op),
    .dst (half_dst),
    .src (half_src),
    .sum (acc_r),
    .key (key_r),
    .res (half_res)
  );

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_nxt       = state_r;
    rounds_left_nxt = rounds_left_r;
    phase_nxt       = phase_r;
    a_nxt           = a_r;
    b_nxt           = b_r;
    acc_nxt         = acc_r;
    xor_nxt         = xor_r;
    chain_nxt       = chain_r;
    out_valid_nxt   = out_valid_r & out_stall;
    out_low_nxt     = out_low_r;
    out_high_nxt    = out_high_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          rounds_left_nxt = round_count_r;
          phase_nxt       = 1'b0;
          if (decrypt_mode_r) begin
            a_nxt     = in_block_low;
            b_nxt     = in_block_high;
            xor_nxt   = chain_sel;
            chain_nxt = {in_block_high, in_block_low};
            acc_nxt   = start_prod[31:0];
          end else begin
            a_nxt     = in_block_low ^ chain_sel[31:0];
            b_nxt     = in_block_high ^ chain_sel[63:32];
            xor_nxt   = '0;
            chain_nxt = chain_sel;
            acc_nxt   = '0;
          end
          state_nxt = (round_count_r == '0) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (dst_is_b) begin
          b_nxt = half_res;
        end else begin
          a_nxt = half_res;
        end
        // The sum steps between the two halves of each cycle.
        if (!phase_r) begin
          acc_nxt = decrypt_mode_r ? (acc_r - XTEA_DELTA) : (acc_r + XTEA_DELTA);
        end else begin
          rounds_left_nxt = rounds_left_r - 8'd1;
          if (rounds_left_r == 8'd1) begin
            state_nxt = ST_DONE;
          end
        end
        phase_nxt = ~phase_r;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_low_nxt   = a_r ^ xor_r[31:0];
          out_high_nxt  = b_r ^ xor_r[63:32];
          if (!decrypt_mode_r) begin
            chain_nxt = {b_r, a_r};
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      rounds_left_r <= '0;
      phase_r       <= 1'b0;
      chain_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      rounds_left_r <= rounds_left_nxt;
      phase_r       <= phase_nxt;
      chain_r       <= chain_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    acc_r      <= acc_nxt;
    xor_r      <= xor_nxt;
    out_low_r  <= out_low_nxt;
    out_high_r <= out_high_nxt;
  end

  // A result appears only out of the finishing state.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result issued outside the finishing state");

  // The round counter never sits at zero while rounds are running.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (rounds_left_r != '0))
    else $error("round sequencer running with no rounds left");

  // The chain changes only on an input transaction or when a block finishes.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!(in_valid && !in_stall) && (state_r != ST_DONE)) |=> $stable(chain_r))
    else $error("chain value changed outside a block boundary");

  // An accepted block keeps the input channel stalled on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a block was still in progress");

endmodule

// ===== sv/xtea_half.sv =====
// ----------------------------------------------------------------------------
// XTEA half round unit
// Computes one Feistel half round: dst +/- (mix(src) ^ (sum + key[sel])).
// ----------------------------------------------------------------------------
module xtea_half import xtea_pkg::*; (
  input  half_op_t    op,
  input  logic [31:0] dst,
  input  logic [31:0] src,
  input  logic [31:0] sum,
  input  key_t        key,
  output logic [31:0] res
);

  logic [31:0] mix;
  logic [1:0]  key_idx;
  logic [31:0] key_word;
  logic [31:0] mixed;

  // Shift and xor mixing of the source word.
  assign mix = ((src << MIX_SHL) ^ (src >> MIX_SHR)) + src;

  // Key word selection from the running sum.
  assign key_idx  = op.sel_hi ? sum[KEY_SEL_SHIFT+1:KEY_SEL_SHIFT] : sum[1:0];
  assign key_word = key[key_idx];

  // Combine with the keyed sum and update the destination word.
  assign mixed = mix ^ (sum + key_word);
  assign res   = op.sub ? (dst - mixed) : (dst + mixed);

endmodule

// ===== tb/sv/xtea_cbc_cipher_tb.sv =====
// ----------------------------------------------------------------------------
// XTEA CBC cipher testbench
// Drives blocks through the cipher under many register settings and idle
// patterns. A scoreboard predicts every CBC result from its own copy of the
// key, IV, mode, round count and chain value, and checks the results in order.
// ----------------------------------------------------------------------------
module xtea_cbc_cipher_tb import xtea_pkg::*; ();

  // Expected output block.
  typedef struct {
    logic [31:0] lo;
    logic [31:0] hi;
  } cipher_block_t;

  // Predicts the CBC result of each accepted block and checks the outputs.
  class cbc_result_board;
    bit            decrypt;
    logic [7:0]    rounds;
    key_t          key;
    logic [31:0]   iv_lo;
    logic [31:0]   iv_hi;
    logic [63:0]   chain;
    cipher_block_t expected_blocks[$];
    int unsigned   mismatch_count;

    function new();
      decrypt        = 1'b0;
      rounds         = 8'd64;
      key            = '0;
      iv_lo          = '0;
      iv_hi          = '0;
      chain          = '0;
      mismatch_count = 0;
    endfunction

    // Mirror a register write; only the low bits of narrow registers count.
    function void write_reg(reg_idx_t idx, logic [31:0] data);
      case (idx)
        REG_DECRYPT_MODE: decrypt = data[0];
        REG_ROUND_COUNT:  rounds = data[7:0];
        REG_KEY_WORD0:    key[0] = data;
        REG_KEY_WORD1:    key[1] = data;
        REG_KEY_WORD2:    key[2] = data;
        REG_KEY_WORD3:    key[3] = data;
        REG_IV_LOW:       iv_lo = data;
        REG_IV_HIGH:      iv_hi = data;
        default: ;
      endcase
    endfunction

    function logic [31:0] feistel_mix(logic [31:0] x);
      return ((x << MIX_SHL) ^ (x >> MIX_SHR)) + x;
    endfunction

    function void encipher(inout logic [31:0] a, inout logic [31:0] b);
      logic [31:0] sum;
      sum = '0;
      for (int n = 0; n < rounds; n++) begin
        a += feistel_mix(b) ^ (sum + key[sum[1:0]]);
        sum += XTEA_DELTA;
        b += feistel_mix(a) ^ (sum + key[sum[KEY_SEL_SHIFT +: 2]]);
      end
    endfunction

    function void decipher(inout logic [31:0] a, inout logic [31:0] b);
      logic [31:0] sum;
      sum = XTEA_DELTA * {24'd0, rounds};
      for (int n = 0; n < rounds; n++) begin
        b -= feistel_mix(a) ^ (sum + key[sum[KEY_SEL_SHIFT +: 2]]);
        sum -= XTEA_DELTA;
        a -= feistel_mix(b) ^ (sum + key[sum[1:0]]);
      end
    endfunction

    // Work out the result of an accepted input transaction and queue it.
    function void note_block(logic [31:0] lo, logic [31:0] hi, logic first);
      logic [63:0]   prev;
      cipher_block_t blk;
      if (first) chain = {iv_hi, iv_lo};
      prev = chain;
      if (!decrypt) begin
        lo ^= prev[31:0];
        hi ^= prev[63:32];
        encipher(lo, hi);
        chain = {hi, lo};
      end else begin
        chain = {hi, lo};
        decipher(lo, hi);
        lo ^= prev[31:0];
        hi ^= prev[63:32];
      end
      blk.lo = lo;
      blk.hi = hi;
      expected_blocks.push_back(blk);
    endfunction

    // Compare a result transaction with the oldest expected block.
    function void check_block(logic [31:0] lo, logic [31:0] hi);
      cipher_block_t blk;
      if (expected_blocks.size() == 0) begin
        $display("%0t: unexpected result %h %h", $time, lo, hi);
        mismatch_count++;
        return;
      end
      blk = expected_blocks.pop_front();
      if (lo !== blk.lo) begin
        $display("%0t: result_low expected %h actual %h", $time, blk.lo, lo);
        mismatch_count++;
      end
      if (hi !== blk.hi) begin
        $display("%0t: result_high expected %h actual %h", $time, blk.hi, hi);
        mismatch_count++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [31:0]        in_block_low = '0;
  logic [31:0]        in_block_high = '0;
  logic               in_first_block = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [31:0]        out_result_low;
  logic [31:0]        out_result_high;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  cbc_result_board sb = new();

  // Idle percentages and the long receiver hold-off request.
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_len = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  xtea_cbc_cipher u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_block_low    (in_block_low),
    .in_block_high   (in_block_high),
    .in_first_block  (in_first_block),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_low  (out_result_low),
    .out_result_high (out_result_high),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, or a long hold-off counted here when requested.
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Check every result transaction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_block(out_result_low, out_result_high);
    end
  end

  // Words biased toward the extremes and single-bit patterns.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return 32'h1 << $urandom_range(31);
      3: return ~(32'h1 << $urandom_range(31));
      default: return $urandom();
    endcase
  endfunction

  // Offer one block and hold it until the block takes it.
  task automatic send_block(input logic [31:0] lo, input logic [31:0] hi,
                            input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_block_low   <= lo;
    in_block_high  <= hi;
    in_first_block <= first;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_block(lo, hi, first);
  endtask

  // Setup and access cycle of one register write; the bus is left selected.
  task automatic reg_write(input reg_idx_t idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Stop offering and let every outstanding result drain.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_blocks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the whole register set; narrow registers get random upper bits.
  task automatic program_regs(input logic mode, input logic [7:0] rounds,
                              input logic [31:0] k0, input logic [31:0] k1,
                              input logic [31:0] k2, input logic [31:0] k3,
                              input logic [31:0] iv_lo, input logic [31:0] iv_hi);
    logic [31:0] mode_word;
    logic [31:0] round_word;
    mode_word       = $urandom();
    mode_word[0]    = mode;
    round_word      = $urandom();
    round_word[7:0] = rounds;
    wait_idle();
    reg_write(REG_DECRYPT_MODE, mode_word);
    reg_write(REG_ROUND_COUNT, round_word);
    reg_write(REG_KEY_WORD0, k0);
    reg_write(REG_KEY_WORD1, k1);
    reg_write(REG_KEY_WORD2, k2);
    reg_write(REG_KEY_WORD3, k3);
    reg_write(REG_IV_LOW, iv_lo);
    reg_write(REG_IV_HIGH, iv_hi);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Main sequence: reset, directed blocks, then random phases.
  initial begin
    logic [7:0]  rounds;
    int          items;
    int          msg_left;
    logic        first;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings; the chain starts at zero without a first block.
    send_block(32'h0, 32'h0, 1'b0);
    send_block('1, '1, 1'b0);

    // Zero rounds leaves the plain CBC XOR, both directions.
    program_regs(1'b0, 8'd0, '0, '1, 32'h0123_4567, 32'h89AB_CDEF, '1, '0);
    send_block(32'h0, 32'h0, 1'b1);
    send_block('1, '1, 1'b0);
    send_block(32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0);
    program_regs(1'b1, 8'd0, '1, '0, '1, '0, '0, '1);
    send_block(32'h0, '1, 1'b1);
    send_block('1, 32'h0, 1'b0);

    // Largest round count, where the decipher sum wraps.
    program_regs(1'b0, 8'd255, '1, '1, '1, '1, $urandom(), $urandom());
    send_block('1, '1, 1'b1);
    send_block(32'h0, 32'h0, 1'b0);
    program_regs(1'b1, 8'd255, '0, '0, '0, '0, '1, '1);
    send_block('1, 32'h0, 1'b1);
    send_block(32'h0, '1, 1'b0);

    // A single round and the default count with messages that restart.
    program_regs(1'b0, 8'd1, $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom());
    send_block(32'h1, 32'h8000_0000, 1'b1);
    send_block($urandom(), $urandom(), 1'b0);
    program_regs(1'b1, 8'd64, $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom());
    send_block($urandom(), $urandom(), 1'b1);
    send_block($urandom(), $urandom(), 1'b0);
    send_block($urandom(), $urandom(), 1'b0);
    program_regs(1'b0, 8'd64, $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom());
    send_block($urandom(), $urandom(), 1'b0);
    send_block($urandom(), $urandom(), 1'b1);
    send_block($urandom(), $urandom(), 1'b0);

    // Random phases: mostly small round counts, messages of random length.
    for (int p = 0; p < 14; p++) begin
      case (p)
        5:       rounds = 8'd255;
        9:       rounds = 8'd64;
        12:      rounds = 8'd0;
        default: rounds = 8'($urandom_range(20, 1));
      endcase
      items = (rounds == 8'd255) ? 6 : 87;
      program_regs(1'($urandom_range(1)), rounds, pick_word(), pick_word(), pick_word(),
                   pick_word(), pick_word(), pick_word());
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 52; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 52; end
        default: begin send_idle_pct = 35; stall_pct = 35; end
      endcase
      msg_left = 0;
      for (int i = 0; i < items; i++) begin
        // Long receiver hold-off while the sender keeps offering blocks.
        if (p == 2 && i == 10) begin
          hold_len = 400;
          hold_seq++;
        end
        if (msg_left == 0) begin
          msg_left = $urandom_range(12, 1);
          first    = 1'b1;
        end else begin
          first = ($urandom_range(9) == 0);
        end
        msg_left--;
        send_block(pick_word(), pick_word(), first);
      end
    end

    // Drain, allow for the longest block latency, then report.
    wait_idle();
    repeat (2 * 255 + 8) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.expected_blocks.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
